// ----- sv/dmpid_pkg.sv -----
package dmpid_pkg;

  localparam int PWM_PERIOD_DEF    = 7200;
  localparam int CHANNEL_COUNT_DEF = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [12:0] DRIVE_LIMIT_RST = 13'd7200;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_DRIVE_COMP     = 3'd4,
    CFG_DRIVE_LIMIT    = 3'd5,
    CFG_ORIENTATION    = 3'd6,
    CFG_AUTO_MODE      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic               channel;
    logic [15:0]        encoder_count;
    logic signed [15:0] target_speed;
  } dmpid_item_t;

  typedef struct packed {
    logic               channel_out;
    logic signed [15:0] speed;
    logic signed [15:0] pid_output;
    logic [12:0]        duty;
    logic [12:0]        compare_value;
    logic               pin_in1;
    logic               pin_in2;
    logic               drive_updated;
  } dmpid_result_t;

endpackage

// ----- sv/dual_motor_pid_speed_drive_unit.sv -----
// Dual-channel PID speed drive. Each transaction on the item channel is one control tick
// for one motor: the raw encoder count is signed by the mounting orientation, and in auto
// mode a fixed-point PID step (error = speed - goal, clamped integral, derivative
// subtracted) produces the saturated PID output, the dead-band compensated and limited
// duty, the timer compare word (period - duty) and the H-bridge pin pair. In manual mode
// only the speed is reported and the controller state is left alone. The block is a
// six-stage pipeline that takes one transaction per clock cycle while the result side does
// not stall. A result is presented from the output register once its item has passed
// through the stage registers, and its transaction completes in a cycle with result_ready
// high. The per-channel state memory is read when an item is accepted and written back
// from stage 1 as that item moves on, and a write-through bypass on the read port lets a
// tick for the same channel follow in the very next cycle. The state memory needs no
// clearing pass after reset; a valid bit per channel makes an unwritten entry read as
// zero. Configuration registers are written through their own channel, which is ready
// whenever reset is low, and must only be changed while no tick is in flight.
module dual_motor_pid_speed_drive_unit
  import dmpid_pkg::*;
#(
  parameter int PWM_PERIOD    = PWM_PERIOD_DEF,
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  dmpid_item_t           item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output dmpid_result_t         result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Address width of the state memory; one bit at least so that a single channel works.
  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [16:0] PERIOD = 17'(PWM_PERIOD);

  // One memory word holds the whole per-channel controller state.
  typedef struct packed {
    logic signed [31:0] integ;
    logic signed [16:0] prev;
  } state_word_t;

  // ---------------------------------------------------------------------------------------
  // Configuration registers. The configuration channel never stalls outside reset.
  // ---------------------------------------------------------------------------------------
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic [30:0]        integral_limit;
  logic [12:0]        drive_compensation;
  logic [12:0]        drive_limit;
  logic               orientation;
  logic               auto_mode;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p             <= '0;
      gain_i             <= '0;
      gain_d             <= '0;
      integral_limit     <= '0;
      drive_compensation <= '0;
      drive_limit        <= DRIVE_LIMIT_RST;
      orientation        <= 1'b0;
      auto_mode          <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GAIN_P:         gain_p             <= cfg_data[15:0];
        CFG_GAIN_I:         gain_i             <= cfg_data[15:0];
        CFG_GAIN_D:         gain_d             <= cfg_data[15:0];
        CFG_INTEGRAL_LIMIT: integral_limit     <= cfg_data[30:0];
        CFG_DRIVE_COMP:     drive_compensation <= cfg_data[12:0];
        CFG_DRIVE_LIMIT:    drive_limit        <= cfg_data[12:0];
        CFG_ORIENTATION:    orientation        <= cfg_data[0];
        CFG_AUTO_MODE:      auto_mode          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves on when it is empty or the next one moves, so a
  // bubble anywhere is squeezed out; a waiting result holds back new transactions only once
  // every stage is full.
  // ---------------------------------------------------------------------------------------
  logic s1_v, s2_v, s3_v, s4_v, s5_v;
  logic s1_en, s2_en, s3_en, s4_en, s5_en, out_en;
  logic item_accept;

  assign out_en      = !result_valid || result_ready;
  assign s5_en       = !s5_v || out_en;
  assign s4_en       = !s4_v || s5_en;
  assign s3_en       = !s3_v || s4_en;
  assign s2_en       = !s2_v || s3_en;
  assign s1_en       = !s1_v || s2_en;
  assign item_ready  = s1_en && !rst;
  assign item_accept = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      s4_v         <= 1'b0;
      s5_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_en)  s1_v         <= item_valid;
      if (s2_en)  s2_v         <= s1_v;
      if (s3_en)  s3_v         <= s2_v;
      if (s4_en)  s4_v         <= s3_v;
      if (s5_en)  s5_v         <= s4_v;
      if (out_en) result_valid <= s5_v;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Input side: speed sign and error are formed on the way in. The orientation bit names
  // the channel whose count is negated, with 16-bit wrap.
  // ---------------------------------------------------------------------------------------
  logic signed [15:0] raw_in;
  logic signed [15:0] speed_in;
  logic signed [16:0] err_in;
  logic               in_range;
  logic               act_in;
  logic [CH_W-1:0]    rd_addr;

  assign raw_in   = $signed(item.encoder_count);
  assign speed_in = (item.channel == orientation) ? -raw_in : raw_in;
  assign err_in   = {speed_in[15], speed_in} - {item.target_speed[15], item.target_speed};
  assign in_range = 32'(item.channel) < CHANNEL_COUNT;
  assign act_in   = auto_mode && in_range;
  assign rd_addr  = in_range ? CH_W'(item.channel) : '0;

  // ---------------------------------------------------------------------------------------
  // State memory, read at accept and written back from stage 1. A write landing on the
  // same edge as a read of the same entry is passed straight into the read register.
  // ---------------------------------------------------------------------------------------
  state_word_t                mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0]   ent_valid;
  state_word_t                rd_word;
  logic                       rd_live;
  logic                       mem_we;
  logic [CH_W-1:0]            wr_addr;
  state_word_t                wr_word;
  logic                       bypass;

  logic               s1_ch;
  logic signed [15:0] s1_speed;
  logic signed [16:0] s1_err;
  logic               s1_act;

  assign wr_addr = CH_W'(s1_ch);
  assign mem_we  = s1_v && s1_act && s2_en;
  assign bypass  = mem_we && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (mem_we) begin
      ent_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      if (bypass) begin
        rd_word <= wr_word;
        rd_live <= 1'b1;
      end else begin
        rd_word <= mem[rd_addr];
        rd_live <= ent_valid[rd_addr];
      end
      s1_ch    <= item.channel;
      s1_speed <= speed_in;
      s1_err   <= err_in;
      s1_act   <= act_in;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: integral update with symmetric clamp, error difference, state write-back.
  // ---------------------------------------------------------------------------------------
  logic signed [31:0] integ_old;
  logic signed [16:0] prev_old;
  logic signed [32:0] integ_sum;
  logic signed [32:0] lim_pos;
  logic signed [32:0] lim_neg;
  logic signed [31:0] integ_new;
  logic signed [17:0] derr;

  assign integ_old = rd_live ? rd_word.integ : '0;
  assign prev_old  = rd_live ? rd_word.prev  : '0;
  assign integ_sum = 33'(integ_old) + 33'(s1_err);
  assign lim_pos   = $signed({2'b00, integral_limit});
  assign lim_neg   = -lim_pos;
  assign derr      = 18'(s1_err) - 18'(prev_old);

  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_new = lim_pos[31:0];
    end else if (integ_sum < lim_neg) begin
      integ_new = lim_neg[31:0];
    end else begin
      integ_new = integ_sum[31:0];
    end
    wr_word.integ = integ_new;
    wr_word.prev  = s1_err;
  end

  logic               s2_ch;
  logic signed [15:0] s2_speed;
  logic               s2_act;
  logic signed [16:0] s2_err;
  logic signed [31:0] s2_integ;
  logic signed [17:0] s2_derr;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_ch    <= s1_ch;
      s2_speed <= s1_speed;
      s2_act   <= s1_act;
      s2_err   <= s1_err;
      s2_integ <= integ_new;
      s2_derr  <= derr;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: the three gain products, each registered.
  // ---------------------------------------------------------------------------------------
  logic               s3_ch;
  logic signed [15:0] s3_speed;
  logic               s3_act;
  logic signed [32:0] s3_prod_p;
  logic signed [47:0] s3_prod_i;
  logic signed [33:0] s3_prod_d;

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_ch     <= s2_ch;
      s3_speed  <= s2_speed;
      s3_act    <= s2_act;
      s3_prod_p <= gain_p * s2_err;
      s3_prod_i <= gain_i * s2_integ;
      s3_prod_d <= gain_d * s2_derr;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: Q42.8 sum of the three terms.
  // ---------------------------------------------------------------------------------------
  logic               s4_ch;
  logic signed [15:0] s4_speed;
  logic               s4_act;
  logic signed [49:0] s4_sum;

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_ch    <= s3_ch;
      s4_speed <= s3_speed;
      s4_act   <= s3_act;
      s4_sum   <= 50'(s3_prod_p) + 50'(s3_prod_i) - 50'(s3_prod_d);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 4: divide by 256 rounding toward zero, then saturate to 16 bits.
  // ---------------------------------------------------------------------------------------
  logic signed [49:0] sum_adj;
  logic signed [41:0] quot;
  logic signed [15:0] pid_sat;

  assign sum_adj = s4_sum + (s4_sum[49] ? 50'sd255 : 50'sd0);
  assign quot    = sum_adj[49:8];

  always_comb begin
    if (quot > 42'sd32767) begin
      pid_sat = 16'sh7FFF;
    end else if (quot < -42'sd32768) begin
      pid_sat = 16'sh8000;
    end else begin
      pid_sat = quot[15:0];
    end
  end

  logic               s5_ch;
  logic signed [15:0] s5_speed;
  logic               s5_act;
  logic signed [15:0] s5_pid;

  always_ff @(posedge clk) begin
    if (s5_en) begin
      s5_ch    <= s4_ch;
      s5_speed <= s4_speed;
      s5_act   <= s4_act;
      s5_pid   <= pid_sat;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 5: drive magnitude. Both directions reduce to min(|pid| + comp, limit), then the
  // duty is held to the PWM period.
  // ---------------------------------------------------------------------------------------
  logic               fwd;
  logic signed [16:0] pid_wide;
  logic [16:0]        pid_abs;
  logic [17:0]        mag_sum;
  logic [12:0]        mag;
  logic [12:0]        duty_val;
  logic [16:0]        cmp_wide;
  logic               pin1;
  dmpid_result_t      result_next;

  assign fwd      = !s5_pid[15];
  assign pid_wide = {s5_pid[15], s5_pid};
  assign pid_abs  = fwd ? pid_wide : -pid_wide;
  assign mag_sum  = {1'b0, pid_abs} + 18'(drive_compensation);
  assign mag      = (mag_sum > 18'(drive_limit)) ? drive_limit : mag_sum[12:0];
  assign duty_val = (17'(mag) > PERIOD) ? PERIOD[12:0] : mag;
  assign cmp_wide = PERIOD - 17'(duty_val);
  assign pin1     = (s5_ch == orientation) ^ !fwd;

  always_comb begin
    result_next             = '0;
    result_next.channel_out = s5_ch;
    result_next.speed       = s5_speed;
    if (s5_act) begin
      result_next.pid_output    = s5_pid;
      result_next.duty          = duty_val;
      result_next.compare_value = cmp_wide[12:0];
      result_next.pin_in1       = pin1;
      result_next.pin_in2       = !pin1;
      result_next.drive_updated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  a_bypass_data : assert property (@(posedge clk) disable iff (rst)
    (item_accept && bypass) |=> (rd_live && rd_word == $past(wr_word)))
    else $error("state read of a channel just written did not see the new value");

  a_manual_quiet : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.drive_updated) |->
      (result.pid_output == 16'sd0 && result.duty == 13'd0 &&
       result.compare_value == 13'd0 && !result.pin_in1 && !result.pin_in2))
    else $error("result without drive update carries drive fields");

  a_pins_opposite : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.drive_updated) |-> (result.pin_in1 != result.pin_in2))
    else $error("H-bridge pins not complementary on a drive update");

  a_duty_limit : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.drive_updated) |->
      (result.duty <= drive_limit && 17'(result.duty) <= PERIOD))
    else $error("duty exceeds drive limit or PWM period");

  a_duty_period : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.drive_updated && PWM_PERIOD < 8192) |->
      (17'(result.duty) + 17'(result.compare_value) == PERIOD))
    else $error("duty and compare word do not add up to the PWM period");

  a_no_write_manual : assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (s1_v && s1_act))
    else $error("state memory written for a tick that runs no PID step");

endmodule
